// ===== rtl/rwhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NO_FMT     = 3'd0;
   localparam logic [2:0] ERR_NO_DATA    = 3'd1;
   localparam logic [2:0] ERR_NEG_LENGTH = 3'd2;
   localparam logic [2:0] ERR_LOW_BITS   = 3'd3;
   localparam logic [2:0] ERR_NO_CHAN    = 3'd4;

   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam int RIFF_HDR_BYTES  = 12;
   localparam int CHUNK_HDR_BYTES = 8;
   localparam int FMT_BODY_BYTES  = 16;
   localparam int MIN_BITS        = 8;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [11:0] sample_width;
      logic [30:0] data_size;
      logic [7:0]  payload_byte;
      logic        last_payload;
      logic [2:0]  error_code;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic entry_type make_error(input logic [2:0] code);
      entry_type e;
      e            = '0;
      e.kind       = KIND_ERROR;
      e.error_code = code;
      return e;
   endfunction

endpackage

// ===== rtl/rwhp_front.sv =====
// ----------------------------------------------------------------------------
// rwhp_front
// Byte parser: walks the RIFF chunk structure and queues header, payload
// and error beats for the back end.
// ----------------------------------------------------------------------------
module rwhp_front
   import rwhp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_stream,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_entry
);

   typedef enum logic [3:0] {
      PH_SKIP_RIFF,
      PH_FMT_HDR,
      PH_FMT_SKIP,
      PH_FMT_BODY,
      PH_FMT_EXCESS,
      PH_DATA_HDR,
      PH_DATA_SKIP,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [30:0] left_ff, left_in;

   logic        accept;
   logic [7:0]  b;
   logic [31:0] len_shift;
   logic [31:0] len_padded;
   logic [31:0] len_dec;
   logic [15:0] bits_new;
   logic [30:0] left_dec;
   logic        want_data;
   logic        neg_len;
   logic        fmt_seen;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_data_byte;

   assign len_shift  = {b, len_ff[31:8]};
   assign len_padded = len_shift + {31'd0, len_shift[0]};
   assign len_dec    = len_ff - 32'd1;
   assign bits_new   = {b, bits_ff[7:0]};
   assign left_dec   = left_ff - 31'd1;
   assign want_data  = (phase_ff == PH_DATA_HDR);
   assign neg_len    = |(len_shift >> (LENGTH_BITS - 1));

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      chan_in    = chan_ff;
      rate_in    = rate_ff;
      bits_in    = bits_ff;
      left_in    = left_ff;
      push       = 1'b0;
      push_entry = '0;
      fmt_seen   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_SKIP_RIFF: begin
               count_in = count_ff + 4'd1;
               if (count_ff == 4'(RIFF_HDR_BYTES - 1)) begin
                  count_in = '0;
                  phase_in = PH_FMT_HDR;
               end
            end
            PH_FMT_HDR, PH_DATA_HDR: begin
               if (count_ff < 4'd4) begin
                  tag_in = {b, tag_ff[31:8]};
               end else begin
                  len_in = len_shift;
               end
               count_in = count_ff + 4'd1;
               if (count_ff == 4'(CHUNK_HDR_BYTES - 1)) begin
                  count_in = '0;
                  if (neg_len) begin
                     push       = 1'b1;
                     push_entry = make_error(ERR_NEG_LENGTH);
                     phase_in   = PH_DONE;
                  end else if (tag_ff == (want_data ? TAG_DATA : TAG_FMT)) begin
                     if (!want_data) begin
                        phase_in = PH_FMT_BODY;
                     end else if (chan_ff == 16'd0) begin
                        push       = 1'b1;
                        push_entry = make_error(ERR_NO_CHAN);
                        phase_in   = PH_DONE;
                     end else begin
                        push                     = 1'b1;
                        push_entry.kind          = KIND_HEADER;
                        push_entry.channel_count = chan_ff;
                        push_entry.sample_rate   = rate_ff;
                        push_entry.sample_width  = bits_ff[14:3];
                        push_entry.data_size     = len_shift[30:0];
                        left_in                  = len_shift[30:0];
                        phase_in = (len_shift == 32'd0) ? PH_DONE : PH_PAYLOAD;
                     end
                  end else begin
                     len_in = len_padded;
                     if (len_padded != 32'd0) begin
                        phase_in = want_data ? PH_DATA_SKIP : PH_FMT_SKIP;
                     end
                  end
               end
            end
            PH_FMT_SKIP, PH_DATA_SKIP, PH_FMT_EXCESS: begin
               len_in = len_dec;
               if (len_dec == 32'd0) begin
                  count_in = '0;
                  phase_in = (phase_ff == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
               end
            end
            PH_FMT_BODY: begin
               if (count_ff == 4'd2) chan_in = {chan_ff[15:8], b};
               if (count_ff == 4'd3) chan_in = {b, chan_ff[7:0]};
               if (count_ff >= 4'd4 && count_ff <= 4'd7) rate_in = {b, rate_ff[31:8]};
               if (count_ff == 4'd14) bits_in = {bits_ff[15:8], b};
               if (count_ff == 4'd15) bits_in = bits_new;
               count_in = count_ff + 4'd1;
               if (count_ff == 4'(FMT_BODY_BYTES - 1)) begin
                  count_in = '0;
                  if (bits_new[15] || bits_new < 16'(MIN_BITS)) begin
                     push       = 1'b1;
                     push_entry = make_error(ERR_LOW_BITS);
                     phase_in   = PH_DONE;
                  end else if (len_ff > 32'(FMT_BODY_BYTES)) begin
                     len_in   = len_ff - 32'(FMT_BODY_BYTES);
                     phase_in = PH_FMT_EXCESS;
                  end else begin
                     phase_in = PH_DATA_HDR;
                  end
               end
            end
            PH_PAYLOAD: begin
               left_in                 = left_dec;
               push                    = 1'b1;
               push_entry.kind         = KIND_PAYLOAD;
               push_entry.payload_byte = b;
               push_entry.last_payload = (left_dec == 31'd0) || req_end_of_stream;
               if (left_dec == 31'd0) phase_in = PH_DONE;
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         fmt_seen = !(phase_in == PH_SKIP_RIFF || phase_in == PH_FMT_HDR ||
                      phase_in == PH_FMT_SKIP);
         if (!push && req_end_of_stream && phase_in != PH_DONE) begin
            push       = 1'b1;
            push_entry = make_error(fmt_seen ? ERR_NO_DATA : ERR_NO_FMT);
         end

         if (req_end_of_stream) begin
            phase_in = PH_SKIP_RIFF;
            count_in = '0;
            tag_in   = '0;
            len_in   = '0;
            chan_in  = '0;
            rate_in  = '0;
            bits_in  = '0;
            left_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP_RIFF;
         count_ff <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         chan_ff  <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== rtl/rwhp_queue.sv =====
// ----------------------------------------------------------------------------
// rwhp_queue
// Short FIFO of parsed beats between the parser and the result stage.
// ----------------------------------------------------------------------------
module rwhp_queue
   import rwhp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head_entry,
   output q_status_type q_status
);

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   fill_ff, fill_in;

   assign head_entry         = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (fill_ff != '0);
   assign q_status.full      = (fill_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(1);
      if (pop)  rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(1);
      if (push && !pop) fill_in = fill_ff + (QUEUE_PTR_BITS+1)'(1);
      if (!push && pop) fill_in = fill_ff - (QUEUE_PTR_BITS+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== rtl/rwhp_back.sv =====
// ----------------------------------------------------------------------------
// rwhp_back
// Result stage: forwards queued beats to the output register and works out
// the frame count of a header with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module rwhp_back
   import rwhp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    head_entry,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_kind,
   output logic [15:0]  rsp_channel_count,
   output logic [31:0]  rsp_sample_rate,
   output logic [11:0]  rsp_sample_width,
   output logic [30:0]  rsp_data_size,
   output logic [30:0]  rsp_frame_count,
   output logic [7:0]   rsp_payload_byte,
   output logic         rsp_last_payload,
   output logic [2:0]   rsp_error_code
);

   localparam int LW       = LENGTH_BITS - 1;
   localparam int CNT_BITS = $clog2(LW);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_WIDTH,
      BK_DIV_CHAN,
      BK_EMIT
   } back_state_type;

   back_state_type      state_ff, state_in;
   entry_type           hold_ff, hold_in;
   logic [LW-1:0]       quo_ff, quo_in;
   logic [15:0]         rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   entry_type           out_ff, out_in;
   logic [30:0]         frame_ff, frame_in;
   logic                out_valid_ff, out_valid_in;

   logic                out_free;
   logic [15:0]         divisor;
   logic [16:0]         trial;
   logic                ge;
   logic [15:0]         rem_step;
   logic [LW-1:0]       quo_step;
   logic                last_step;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pop       = (state_ff == BK_IDLE) && q_status.not_empty && out_free;
   assign divisor   = (state_ff == BK_DIV_WIDTH) ? {4'd0, hold_ff.sample_width}
                                                 : hold_ff.channel_count;
   assign trial     = {rem_ff, quo_ff[LW-1]};
   assign ge        = (trial >= {1'b0, divisor});
   assign rem_step  = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
   assign quo_step  = {quo_ff[LW-2:0], ge};
   assign last_step = (cnt_ff == CNT_BITS'(LW - 1));

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      frame_in     = frame_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               if (head_entry.kind == KIND_HEADER) begin
                  hold_in  = head_entry;
                  quo_in   = head_entry.data_size[LW-1:0];
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = BK_DIV_WIDTH;
               end else begin
                  out_in       = head_entry;
                  frame_in     = '0;
                  out_valid_in = 1'b1;
               end
            end
         end
         BK_DIV_WIDTH, BK_DIV_CHAN: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = (state_ff == BK_DIV_WIDTH) ? BK_DIV_CHAN : BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               out_in       = hold_ff;
               frame_in     = 31'(quo_ff);
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      hold_ff  <= hold_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      out_ff   <= out_in;
      frame_ff <= frame_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_channel_count = out_ff.channel_count;
   assign rsp_sample_rate   = out_ff.sample_rate;
   assign rsp_sample_width  = out_ff.sample_width;
   assign rsp_data_size     = out_ff.data_size;
   assign rsp_frame_count   = frame_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_last_payload  = out_ff.last_payload;
   assign rsp_error_code    = out_ff.error_code;

endmodule

// ===== rtl/riff_wav_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// riff_wav_header_parser_unit
// Parses a WAV byte stream and reports the format, payload bytes and errors.
// ----------------------------------------------------------------------------
// Input channel (req_): one file byte per beat, req_end_of_stream on the last
//   byte of a file; the next beat then starts a new file.
// Result channel (rsp_): kind 0 is the header beat (format fields, data size,
//   frame count), kind 1 a payload byte, kind 2 an error with its code.
// The parser takes one byte per cycle while req_stall is low and writes its
// beats into a four-entry queue; a result stage drains the queue into the
// output register. With the queue empty and rsp_ free, a payload or error
// beat goes from its queue slot straight into the output register.
// A header beat first goes through two serial divisions, by the sample width
// and then by the channel count, before it is on rsp_.
// Throughput: one byte per cycle, except behind a header or while rsp_ stalls,
// where the queue fills and req_stall rises until it drains.
// req_stall is high exactly when the queue is full; a stalled rsp_ beat holds
// its value, and the queue keeps taking bytes until it is full.
// Synchronous reset clears parser state, queue and output valid; the first
// byte after reset is the first byte of a file.
// ----------------------------------------------------------------------------
module riff_wav_header_parser_unit
   import rwhp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [11:0] rsp_sample_width,
   output logic [30:0] rsp_data_size,
   output logic [30:0] rsp_frame_count,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_payload,
   output logic [2:0]  rsp_error_code
);

   q_status_type q_status;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    head_entry;

   rwhp_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   rwhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   rwhp_back #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_sample_width  (rsp_sample_width),
      .rsp_data_size     (rsp_data_size),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_payload  (rsp_last_payload),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

// ===== rtl/rwhp_checker.sv =====
// ----------------------------------------------------------------------------
// rwhp_checker
// Port-level checks on the result channel of the header parser.
// ----------------------------------------------------------------------------
module rwhp_checker
   import rwhp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_channel_count,
   input logic [11:0] rsp_sample_width,
   input logic [30:0] rsp_frame_count,
   input logic [7:0]  rsp_payload_byte,
   input logic [2:0]  rsp_error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
                                && $stable(rsp_payload_byte))
      else $error("stalled result beat changed");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_HEADER || rsp_kind == KIND_PAYLOAD
                    || rsp_kind == KIND_ERROR)
      else $error("unknown result kind");

   a_header_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER
         |-> rsp_channel_count != 16'd0 && rsp_sample_width != 12'd0)
      else $error("header beat with zero channels or width");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD
         |-> rsp_frame_count == 31'd0 && rsp_error_code == 3'd0
             && rsp_channel_count == 16'd0)
      else $error("payload beat carries header or error fields");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_error_code <= ERR_NO_CHAN
                                              && rsp_payload_byte == 8'd0)
      else $error("bad error beat");

endmodule

bind riff_wav_header_parser_unit rwhp_checker u_rwhp_checker (.*);
